// ===== rtl/core/bilinear_image_resize_macros.svh =====
// Assertion macros for the bilinear image resize block.
// Used by the top level only; expands to nothing in synthesis.
`ifndef BILINEAR_IMAGE_RESIZE_MACROS_SVH
`define BILINEAR_IMAGE_RESIZE_MACROS_SVH
`ifndef SYNTHESIS
`define BRS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define BRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define BRS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BRS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/brs_pkg.sv =====
// Shared types and constants of the bilinear image resize block.
// No dependencies; used by brs_store and bilinear_image_resize.
`default_nettype none
package brs_pkg;
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
   localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd1;
   localparam logic [2:0] REG_TARGET_WIDTH  = 3'd2;
   localparam logic [2:0] REG_TARGET_HEIGHT = 3'd3;
   localparam logic [2:0] REG_STEP_HORIZ    = 3'd4;
   localparam logic [2:0] REG_STEP_VERT     = 3'd5;

   localparam logic       REQ_LOAD   = 1'b0;
   localparam logic       REQ_SAMPLE = 1'b1;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] CHANNEL_MAX  = 8'hFF;
endpackage
`default_nettype wire

// ===== rtl/core/brs_store.sv =====
// Frame store split into four banks by row and column parity.
// Depends on brs_pkg; one write and one registered read per bank per cycle.
`default_nettype none
module brs_store
   import brs_pkg::*;
#(
   parameter int MAX_W = 512,
   parameter int MAX_H = 512,
   parameter int CW    = 9,
   parameter int RW    = 9
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [CW-1:0] x0,
   input  wire logic [CW-1:0] x1,
   input  wire logic [RW-1:0] y0,
   input  wire logic [RW-1:0] y1,
   input  wire logic          wr_en,
   input  wire logic [CW-1:0] wr_col,
   input  wire logic [RW-1:0] wr_row,
   input  wire pixel_type     wr_data,
   output pixel_type          p00,
   output pixel_type          p01,
   output pixel_type          p10,
   output pixel_type          p11
);
   localparam int HALF_W = (MAX_W + 1) / 2;
   localparam int HALF_H = (MAX_H + 1) / 2;
   localparam int BANK_DEPTH = HALF_W * HALF_H;
   localparam int BAW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   pixel_type rd_ff [4];
   logic x0p_ff, x1p_ff, y0p_ff, y1p_ff;

   logic [23:0] wr_addr_full;
   assign wr_addr_full = 24'(wr_row >> 1) * 24'(HALF_W) + 24'(wr_col >> 1);

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam logic PC = 1'(b % 2);
      localparam logic PR = 1'(b / 2);
      pixel_type mem [BANK_DEPTH];
      logic [CW-1:0] col;
      logic [RW-1:0] row;
      logic [23:0]   rd_addr_full;

      // Each bank serves the neighbor column and row of its own parity.
      assign col = (x0[0] == PC) ? x0 : x1;
      assign row = (y0[0] == PR) ? y0 : y1;
      assign rd_addr_full = 24'(row >> 1) * 24'(HALF_W) + 24'(col >> 1);

      always_ff @(posedge clock) begin
         if (wr_en && wr_col[0] == PC && wr_row[0] == PR) begin
            mem[wr_addr_full[BAW-1:0]] <= wr_data;
         end
         if (rd_en) begin
            rd_ff[b] <= mem[rd_addr_full[BAW-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         x0p_ff <= x0[0];
         x1p_ff <= x1[0];
         y0p_ff <= y0[0];
         y1p_ff <= y1[0];
      end
   end

   assign p00 = rd_ff[{y0p_ff, x0p_ff}];
   assign p01 = rd_ff[{y0p_ff, x1p_ff}];
   assign p10 = rd_ff[{y1p_ff, x0p_ff}];
   assign p11 = rd_ff[{y1p_ff, x1p_ff}];
endmodule
`default_nettype wire

// ===== rtl/core/bilinear_image_resize.sv =====
// Bilinear frame-store scaler with half-pixel centers: an item enters and a result leaves
// every cycle unless a held response stalls the flow, through the six-register pipeline
// (coordinate multiply, clamp, banked store read, weight multiply, channel multiply,
// sum and limit). Loads travel down the pipeline with the samples and write the store
// at the read stage, so every sample sees exactly the loads accepted before it; loads
// give no response. Four neighbor reads per cycle, while the pipeline advances, come
// from a store banked by row and column parity.
// Depends on brs_pkg, brs_store and bilinear_image_resize_macros.svh.
`default_nettype none
`include "bilinear_image_resize_macros.svh"
module bilinear_image_resize
   import brs_pkg::*;
#(
   parameter int MAX_SOURCE_WIDTH  = 512,
   parameter int MAX_SOURCE_HEIGHT = 512,
   parameter int FRACTION_BITS     = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [8:0]  req_load_column,
   input  wire logic [8:0]  req_load_row,
   input  wire logic [7:0]  req_in_red,
   input  wire logic [7:0]  req_in_green,
   input  wire logic [7:0]  req_in_blue,
   input  wire logic [7:0]  req_in_alpha,
   input  wire logic [11:0] req_sample_column,
   input  wire logic [11:0] req_sample_row,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic [7:0]       rsp_out_alpha,
   output logic [11:0]      rsp_pixel_column,
   output logic [11:0]      rsp_pixel_row,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   localparam int FB = FRACTION_BITS;
   localparam int CW = $clog2(MAX_SOURCE_WIDTH);
   localparam int RW = $clog2(MAX_SOURCE_HEIGHT);
   localparam int TW = 39;
   localparam int XW = CW + FB;
   localparam int YW = RW + FB;
   localparam int GW = FB + 1;
   localparam int WW = 2 * GW;
   localparam int PW = WW + 8;
   localparam int SW = PW + 2;

   // Configuration registers.
   logic [9:0]  src_w_ff, src_h_ff;
   logic [12:0] tgt_w_ff, tgt_h_ff;
   logic [25:0] step_h_ff, step_v_ff;
   logic        csr_write;

   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff  <= 10'd512;
         src_h_ff  <= 10'd512;
         tgt_w_ff  <= 13'd512;
         tgt_h_ff  <= 13'd512;
         step_h_ff <= 26'(1) << FB;
         step_v_ff <= 26'(1) << FB;
      end else if (csr_write) begin
         case (paddr[4:2])
            REG_SOURCE_WIDTH:  src_w_ff  <= pwdata[9:0];
            REG_SOURCE_HEIGHT: src_h_ff  <= pwdata[9:0];
            REG_TARGET_WIDTH:  tgt_w_ff  <= pwdata[12:0];
            REG_TARGET_HEIGHT: tgt_h_ff  <= pwdata[12:0];
            REG_STEP_HORIZ:    step_h_ff <= pwdata[25:0];
            REG_STEP_VERT:     step_v_ff <= pwdata[25:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_SOURCE_WIDTH:  prdata = 32'(src_w_ff);
         REG_SOURCE_HEIGHT: prdata = 32'(src_h_ff);
         REG_TARGET_WIDTH:  prdata = 32'(tgt_w_ff);
         REG_TARGET_HEIGHT: prdata = 32'(tgt_h_ff);
         REG_STEP_HORIZ:    prdata = 32'(step_h_ff);
         REG_STEP_VERT:     prdata = 32'(step_v_ff);
         default:           prdata = 32'd0;
      endcase
   end

   // Saturated source size; the user must change configuration only while the pipeline is empty (not enforced here).
   logic [12:0]   sw13, sh13;
   logic [CW-1:0] sw_m1;
   logic [RW-1:0] sh_m1;
   logic [12:0]   sw_m1_13, sh_m1_13;
   always_comb begin
      sw13 = (src_w_ff == 10'd0) ? 13'd1 :
             (13'(src_w_ff) > 13'(MAX_SOURCE_WIDTH)) ? 13'(MAX_SOURCE_WIDTH) : 13'(src_w_ff);
      sh13 = (src_h_ff == 10'd0) ? 13'd1 :
             (13'(src_h_ff) > 13'(MAX_SOURCE_HEIGHT)) ? 13'(MAX_SOURCE_HEIGHT) : 13'(src_h_ff);
      sw_m1_13 = sw13 - 13'd1;
      sh_m1_13 = sh13 - 13'd1;
      sw_m1 = sw_m1_13[CW-1:0];
      sh_m1 = sh_m1_13[RW-1:0];
   end

   logic advance, accept;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;

   // Loads inside the store enter the pipeline beside the samples.
   logic [12:0] lc13, lr13;
   logic        load_en;
   pixel_type   load_px;
   assign lc13 = 13'(req_load_column);
   assign lr13 = 13'(req_load_row);
   assign load_en = accept && (req_type == REQ_LOAD) &&
                    (lc13 < 13'(MAX_SOURCE_WIDTH)) && (lr13 < 13'(MAX_SOURCE_HEIGHT));
   assign load_px = '{alpha: req_in_alpha, blue: req_in_blue,
                      green: req_in_green, red: req_in_red};

   // Stage 1: (2d+1)*step and the equal-size coordinates.
   logic          v1_ff, eq1_ff;
   logic [TW-1:0] tx1_ff, ty1_ff;
   logic [CW-1:0] ce1_ff;
   logic [RW-1:0] re1_ff;
   logic [11:0]   dc1_ff, dr1_ff;
   logic          ld1_ff;
   logic [CW-1:0] lc1_ff;
   logic [RW-1:0] lr1_ff;
   pixel_type     lpx1_ff;
   logic          eq_in;
   logic [CW-1:0] ce_in;
   logic [RW-1:0] re_in;
   assign eq_in = (13'(src_w_ff) == tgt_w_ff) && (13'(src_h_ff) == tgt_h_ff);
   assign ce_in = (13'(req_sample_column) < sw13) ? req_sample_column[CW-1:0] : sw_m1;
   assign re_in = (13'(req_sample_row) < sh13) ? req_sample_row[RW-1:0] : sh_m1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         ld1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff  <= accept && (req_type == REQ_SAMPLE);
         ld1_ff <= load_en;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         eq1_ff  <= eq_in;
         tx1_ff  <= TW'({req_sample_column, 1'b1}) * TW'(step_h_ff);
         ty1_ff  <= TW'({req_sample_row, 1'b1}) * TW'(step_v_ff);
         ce1_ff  <= ce_in;
         re1_ff  <= re_in;
         dc1_ff  <= req_sample_column;
         dr1_ff  <= req_sample_row;
         lc1_ff  <= lc13[CW-1:0];
         lr1_ff  <= lr13[RW-1:0];
         lpx1_ff <= load_px;
      end
   end

   // Stage 2: subtract the half pixel, floor and clamp.
   logic          v2_ff, eq2_ff;
   logic [XW-1:0] sx2_ff;
   logic [YW-1:0] sy2_ff;
   logic [11:0]   dc2_ff, dr2_ff;
   logic          ld2_ff;
   logic [CW-1:0] lc2_ff;
   logic [RW-1:0] lr2_ff;
   pixel_type     lpx2_ff;
   logic [TW-1:0] half, top_x, top_y, sx_full, sy_full;
   logic [XW-1:0] sx_in;
   logic [YW-1:0] sy_in;
   always_comb begin
      half  = TW'(1) << FB;
      top_x = TW'(sw_m1) << FB;
      top_y = TW'(sh_m1) << FB;
      sx_full = (tx1_ff <= half) ? '0 : ((tx1_ff - half) >> 1);
      sy_full = (ty1_ff <= half) ? '0 : ((ty1_ff - half) >> 1);
      if (sx_full > top_x) sx_full = top_x;
      if (sy_full > top_y) sy_full = top_y;
      sx_in = eq1_ff ? {ce1_ff, FB'(0)} : sx_full[XW-1:0];
      sy_in = eq1_ff ? {re1_ff, FB'(0)} : sy_full[YW-1:0];
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff  <= 1'b0;
         ld2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff  <= v1_ff;
         ld2_ff <= ld1_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         eq2_ff  <= eq1_ff;
         sx2_ff  <= sx_in;
         sy2_ff  <= sy_in;
         dc2_ff  <= dc1_ff;
         dr2_ff  <= dr1_ff;
         lc2_ff  <= lc1_ff;
         lr2_ff  <= lr1_ff;
         lpx2_ff <= lpx1_ff;
      end
   end

   // Stage 3: neighbor addresses into the banked store. The load in this stage, if any,
   // writes at the same edge at which a sample here would read.
   logic [CW-1:0] x0, x1;
   logic [RW-1:0] y0, y1;
   logic          store_wr;
   assign x0 = sx2_ff[XW-1:FB];
   assign y0 = sy2_ff[YW-1:FB];
   assign x1 = (x0 == sw_m1) ? x0 : x0 + CW'(1);
   assign y1 = (y0 == sh_m1) ? y0 : y0 + RW'(1);
   assign store_wr = ld2_ff && advance;

   pixel_type p00, p01, p10, p11;
   brs_store #(
      .MAX_W(MAX_SOURCE_WIDTH),
      .MAX_H(MAX_SOURCE_HEIGHT),
      .CW(CW),
      .RW(RW)
   ) u_store (
      .clock  (clock),
      .rd_en  (advance),
      .x0     (x0),
      .x1     (x1),
      .y0     (y0),
      .y1     (y1),
      .wr_en  (store_wr),
      .wr_col (lc2_ff),
      .wr_row (lr2_ff),
      .wr_data(lpx2_ff),
      .p00    (p00),
      .p01    (p01),
      .p10    (p10),
      .p11    (p11)
   );

   logic          v3_ff, eq3_ff;
   logic [FB-1:0] fx3_ff, fy3_ff;
   logic [11:0]   dc3_ff, dr3_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (advance) begin
         v3_ff <= v2_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         eq3_ff <= eq2_ff;
         fx3_ff <= sx2_ff[FB-1:0];
         fy3_ff <= sy2_ff[FB-1:0];
         dc3_ff <= dc2_ff;
         dr3_ff <= dr2_ff;
      end
   end

   // Stage 4: corner weights.
   logic [GW-1:0] fx, fy, gx, gy;
   assign fx = GW'(fx3_ff);
   assign fy = GW'(fy3_ff);
   assign gx = (GW'(1) << FB) - fx;
   assign gy = (GW'(1) << FB) - fy;

   logic          v4_ff, eq4_ff;
   logic [WW-1:0] w4_ff [4];
   pixel_type     px4_ff [4];
   logic [11:0]   dc4_ff, dr4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (advance) begin
         v4_ff <= v3_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         eq4_ff    <= eq3_ff;
         w4_ff[0]  <= WW'(gx) * WW'(gy);
         w4_ff[1]  <= WW'(fx) * WW'(gy);
         w4_ff[2]  <= WW'(gx) * WW'(fy);
         w4_ff[3]  <= WW'(fx) * WW'(fy);
         px4_ff[0] <= p00;
         px4_ff[1] <= p01;
         px4_ff[2] <= p10;
         px4_ff[3] <= p11;
         dc4_ff    <= dc3_ff;
         dr4_ff    <= dr3_ff;
      end
   end

   // Stage 5: channel times weight, three channels by four corners.
   logic          v5_ff, eq5_ff;
   logic [PW-1:0] prod5_ff [3][4];
   logic [7:0]    alpha5_ff;
   logic [11:0]   dc5_ff, dr5_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= v4_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 4; k++) begin
            prod5_ff[0][k] <= PW'(px4_ff[k].red)   * PW'(w4_ff[k]);
            prod5_ff[1][k] <= PW'(px4_ff[k].green) * PW'(w4_ff[k]);
            prod5_ff[2][k] <= PW'(px4_ff[k].blue)  * PW'(w4_ff[k]);
         end
         eq5_ff    <= eq4_ff;
         alpha5_ff <= px4_ff[0].alpha;
         dc5_ff    <= dc4_ff;
         dr5_ff    <= dr4_ff;
      end
   end

   // Stage 6: sum, drop the fraction and limit to a byte.
   logic [7:0] chan_in [3];
   always_comb begin
      logic [SW-1:0] sum;
      logic [SW-1:0] val;
      for (int c = 0; c < 3; c++) begin
         sum = SW'(prod5_ff[c][0]) + SW'(prod5_ff[c][1]) +
               SW'(prod5_ff[c][2]) + SW'(prod5_ff[c][3]);
         val = sum >> (2 * FB);
         chan_in[c] = (val > SW'(CHANNEL_MAX)) ? CHANNEL_MAX : val[7:0];
      end
   end

   logic        rsp_valid_ff, eq6_ff;
   logic [7:0]  red_ff, green_ff, blue_ff, alpha_ff;
   logic [11:0] col_ff, row_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= v5_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         red_ff   <= chan_in[0];
         green_ff <= chan_in[1];
         blue_ff  <= chan_in[2];
         alpha_ff <= eq5_ff ? alpha5_ff : ALPHA_OPAQUE;
         eq6_ff   <= eq5_ff;
         col_ff   <= dc5_ff;
         row_ff   <= dr5_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_red      = red_ff;
   assign rsp_out_green    = green_ff;
   assign rsp_out_blue     = blue_ff;
   assign rsp_out_alpha    = alpha_ff;
   assign rsp_pixel_column = col_ff;
   assign rsp_pixel_row    = row_ff;

   `BRS_ASSERT_NEXT(a_load_no_result, clock, reset, accept && req_type == REQ_LOAD, !v1_ff)
   `BRS_ASSERT_NEXT(a_sample_enters, clock, reset, accept && req_type == REQ_SAMPLE, v1_ff)
   `BRS_ASSERT_IMPL(a_alpha_opaque, clock, reset, rsp_valid && !eq6_ff, alpha_ff == ALPHA_OPAQUE)
   `BRS_ASSERT_NEXT(a_stall_holds, clock, reset, !advance, $stable(v5_ff) && $stable(v2_ff))
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the bilinear_image_resize frame-store scaler.
// Depends on brs_pkg and the bilinear_image_resize RTL only.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import brs_pkg::*;

   localparam int STORE_W = 512;
   localparam int STORE_H = 512;
   localparam int FRAC = 16;
   localparam int SETTLE_CYCLES = 20;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic        kind;
      logic [8:0]  load_col;
      logic [8:0]  load_row;
      logic [7:0]  red, green, blue, alpha;
      logic [11:0] dst_col;
      logic [11:0] dst_row;
   } pixel_request_type;

   typedef struct {
      logic [7:0]  red, green, blue, alpha;
      logic [11:0] col;
      logic [11:0] row;
   } blended_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_type = REQ_LOAD;
   logic [8:0] req_load_column = '0, req_load_row = '0;
   logic [7:0] req_in_red = '0, req_in_green = '0, req_in_blue = '0, req_in_alpha = '0;
   logic [11:0] req_sample_column = '0, req_sample_row = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha;
   logic [11:0] rsp_pixel_column, rsp_pixel_row;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   bilinear_image_resize dut (.*);

   // Testbench copy of the frame store and the scaler registers.
   logic [31:0] frame_copy [0:STORE_W*STORE_H-1];
   logic [9:0]  src_w_reg = 10'd512, src_h_reg = 10'd512;
   logic [12:0] dst_w_reg = 13'd512, dst_h_reg = 13'd512;
   logic [25:0] step_h_reg = 26'd65536, step_v_reg = 26'd65536;

   pixel_request_type pending_requests [$];
   blended_pixel_type awaited_pixels [$];

   int mismatches = 0;
   int unmatched = 0;
   int loads_seen = 0, samples_seen = 0, phases_run = 0;
   int cycles = 0;
   int send_idle_pct = 0, recv_idle_pct = 0;
   int hold_requests = 0;
   logic taken = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [63:0] source_coord(logic [11:0] d, logic [25:0] step,
                                                logic [9:0] size);
      logic [63:0] t, half, top, s;
      t = (2 * 64'(d) + 1) * 64'(step);
      half = 64'd1 << FRAC;
      top = (64'(size) - 1) << FRAC;
      if (t <= half) return 64'd0;
      s = (t - half) >> 1;
      return (s > top) ? top : s;
   endfunction

   function automatic logic [31:0] stored_pixel(logic [63:0] col, logic [63:0] row);
      return frame_copy[row * STORE_W + col];
   endfunction

   function automatic blended_pixel_type predict_pixel(pixel_request_type rq);
      blended_pixel_type p;
      logic [9:0] sw, sh;
      logic [63:0] sx, sy, x0, y0, x1, y1, fx, fy, gx, gy, sum, v, col, row;
      logic [31:0] p00, p01, p10, p11, px;
      sw = (src_w_reg == 0) ? 10'd1 : (src_w_reg > STORE_W) ? 10'(STORE_W) : src_w_reg;
      sh = (src_h_reg == 0) ? 10'd1 : (src_h_reg > STORE_H) ? 10'(STORE_H) : src_h_reg;
      p.col = rq.dst_col;
      p.row = rq.dst_row;
      if (13'(src_w_reg) == dst_w_reg && 13'(src_h_reg) == dst_h_reg) begin
         col = (rq.dst_col < sw) ? 64'(rq.dst_col) : 64'(sw) - 1;
         row = (rq.dst_row < sh) ? 64'(rq.dst_row) : 64'(sh) - 1;
         px = stored_pixel(col, row);
         {p.alpha, p.blue, p.green, p.red} = px;
         return p;
      end
      sx = source_coord(rq.dst_col, step_h_reg, sw);
      sy = source_coord(rq.dst_row, step_v_reg, sh);
      x0 = sx >> FRAC;
      y0 = sy >> FRAC;
      fx = sx & ((64'd1 << FRAC) - 1);
      fy = sy & ((64'd1 << FRAC) - 1);
      x1 = (x0 + 1 < sw) ? x0 + 1 : 64'(sw) - 1;
      y1 = (y0 + 1 < sh) ? y0 + 1 : 64'(sh) - 1;
      gx = (64'd1 << FRAC) - fx;
      gy = (64'd1 << FRAC) - fy;
      p00 = stored_pixel(x0, y0);
      p01 = stored_pixel(x1, y0);
      p10 = stored_pixel(x0, y1);
      p11 = stored_pixel(x1, y1);
      for (int c = 0; c < 3; c++) begin
         sum = 64'((p00 >> (8*c)) & 8'hFF) * gx * gy + 64'((p01 >> (8*c)) & 8'hFF) * fx * gy
             + 64'((p10 >> (8*c)) & 8'hFF) * gx * fy + 64'((p11 >> (8*c)) & 8'hFF) * fx * fy;
         v = sum >> (2 * FRAC);
         if (v > 255) v = 255;
         case (c)
            0: p.red = v[7:0];
            1: p.green = v[7:0];
            default: p.blue = v[7:0];
         endcase
      end
      p.alpha = ALPHA_OPAQUE;
      return p;
   endfunction

   // Request driver: a new transaction is presented only after the previous one was taken.
   always @(negedge clock) begin
      pixel_request_type rq;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || taken) begin
         if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            rq = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_type <= rq.kind;
            req_load_column <= rq.load_col;
            req_load_row <= rq.load_row;
            req_in_red <= rq.red;
            req_in_green <= rq.green;
            req_in_blue <= rq.blue;
            req_in_alpha <= rq.alpha;
            req_sample_column <= rq.dst_col;
            req_sample_row <= rq.dst_row;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response ready, with long hold-offs counted here on request.
   int hold_left = 0;
   int hold_served = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Request monitor: updates the store copy and predicts each sample result.
   always @(posedge clock) begin
      pixel_request_type rq;
      taken <= req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         rq.kind = req_type;
         rq.load_col = req_load_column;
         rq.load_row = req_load_row;
         rq.red = req_in_red;
         rq.green = req_in_green;
         rq.blue = req_in_blue;
         rq.alpha = req_in_alpha;
         rq.dst_col = req_sample_column;
         rq.dst_row = req_sample_row;
         if (rq.kind == REQ_LOAD) begin
            frame_copy[32'(rq.load_row) * STORE_W + 32'(rq.load_col)] =
               {rq.alpha, rq.blue, rq.green, rq.red};
            loads_seen++;
         end else begin
            awaited_pixels.push_back(predict_pixel(rq));
            samples_seen++;
         end
      end
   end

   // Result checker.
   always @(posedge clock) begin
      blended_pixel_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_pixels.size() == 0) begin
            unmatched++;
            $display("unexpected result at (%0d,%0d)", rsp_pixel_column, rsp_pixel_row);
         end else begin
            e = awaited_pixels.pop_front();
            if (rsp_out_red !== e.red || rsp_out_green !== e.green
                || rsp_out_blue !== e.blue || rsp_out_alpha !== e.alpha
                || rsp_pixel_column !== e.col || rsp_pixel_row !== e.row) begin
               if (mismatches < 10)
                  $display("mismatch: exp %h %h %h %h (%0d,%0d) got %h %h %h %h (%0d,%0d)",
                           e.red, e.green, e.blue, e.alpha, e.col, e.row,
                           rsp_out_red, rsp_out_green, rsp_out_blue, rsp_out_alpha,
                           rsp_pixel_column, rsp_pixel_row);
               mismatches++;
            end
         end
      end
   end

   task automatic write_register(logic [2:0] index, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 5'(index) << 2;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_SOURCE_WIDTH:  src_w_reg = value[9:0];
         REG_SOURCE_HEIGHT: src_h_reg = value[9:0];
         REG_TARGET_WIDTH:  dst_w_reg = value[12:0];
         REG_TARGET_HEIGHT: dst_h_reg = value[12:0];
         REG_STEP_HORIZ:    step_h_reg = value[25:0];
         REG_STEP_VERT:     step_v_reg = value[25:0];
         default: ;
      endcase
   endtask

   // Blocks until every request is taken and every result has come back.
   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || awaited_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_load(int col, int row);
      pixel_request_type rq;
      rq.kind = REQ_LOAD;
      rq.load_col = 9'(col);
      rq.load_row = 9'(row);
      {rq.red, rq.green, rq.blue, rq.alpha} = $urandom;
      {rq.dst_col, rq.dst_row} = 24'($urandom);
      pending_requests.push_back(rq);
   endtask

   task automatic queue_sample(int col, int row);
      pixel_request_type rq;
      rq.kind = REQ_SAMPLE;
      {rq.load_col, rq.load_row} = 18'($urandom);
      {rq.red, rq.green, rq.blue, rq.alpha} = $urandom;
      rq.dst_col = 12'(col);
      rq.dst_row = 12'(row);
      pending_requests.push_back(rq);
   endtask

   // Programs the scaler, loads the used source area from first_col on, then mixes
   // samples and reloads. Columns left of first_col must never be read in the phase.
   task automatic run_resize_phase(int sw, int sh, int tw, int th, int step_h, int step_v,
                                   int mixed_items, int first_col);
      int w, h;
      wait_drained();
      write_register(REG_SOURCE_WIDTH, sw);
      write_register(REG_SOURCE_HEIGHT, sh);
      write_register(REG_TARGET_WIDTH, tw);
      write_register(REG_TARGET_HEIGHT, th);
      write_register(REG_STEP_HORIZ, step_h);
      write_register(REG_STEP_VERT, step_v);
      w = (sw == 0) ? 1 : (sw > STORE_W) ? STORE_W : sw;
      h = (sh == 0) ? 1 : (sh > STORE_H) ? STORE_H : sh;
      for (int r = 0; r < h; r++)
         for (int c = first_col; c < w; c++)
            queue_load(c, r);
      for (int i = 0; i < mixed_items; i++) begin
         if ($urandom_range(99) < 25)
            queue_load($urandom_range(first_col, w - 1), $urandom_range(h - 1));
         else if ($urandom_range(9) == 0)
            queue_sample($urandom_range(4095), $urandom_range(4095));
         else
            queue_sample($urandom_range(tw + 1), $urandom_range(th + 1));
      end
      phases_run++;
   endtask

   initial begin
      int sw, sh, tw, th;
      for (int i = 0; i < STORE_W * STORE_H; i++) frame_copy[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: equal sizes return the stored pixel, alpha included, with clamping.
      send_idle_pct = 13;
      recv_idle_pct = 50;
      run_resize_phase(4, 3, 4, 3, 65536, 65536, 0, 0);
      pending_requests[0].red = 8'h00;
      pending_requests[11].red = 8'hFF;
      pending_requests[11].alpha = 8'h00;
      queue_sample(0, 0);
      queue_sample(3, 2);
      queue_sample(4095, 4095);
      queue_sample(4095, 0);
      queue_sample(0, 4095);
      queue_sample(2, 1);
      // Upscale and downscale, covering corner clamps and zero/extreme steps.
      run_resize_phase(2, 2, 5, 3, (2 << 16) / 5, (2 << 16) / 3, 0, 0);
      queue_sample(0, 0);
      queue_sample(4, 2);
      queue_sample(4095, 4095);
      queue_sample(2, 1);
      run_resize_phase(3, 2, 1, 1, 0, 26'h3FFFFFF, 4, 0);

      // Out-of-range source sizes. With the largest step every column clamps to the
      // last one, so only the right end of the saturated row needs loading.
      run_resize_phase(1023, 0, 8191, 4096, 26'h3FFFFFF, 1, 40, STORE_W - 8);
      run_resize_phase(0, 9, 1, 5, 1, (9 << 16) / 5, 40, 0);
      run_resize_phase(9, 2, 9, 2, 65536, 65536, 40, 0);

      for (int p = 0; p < 12; p++) begin
         if (p == 4) begin
            send_idle_pct = 50;
            recv_idle_pct = 13;
         end else if (p == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         sw = $urandom_range(1, 8);
         sh = $urandom_range(1, 8);
         tw = $urandom_range(1, 24);
         th = $urandom_range(1, 24);
         if ($urandom_range(3) == 0) begin
            tw = sw;
            th = sh;
         end
         run_resize_phase(sw, sh, tw, th,
                          ($urandom_range(4) == 0) ? $urandom_range(1, 1 << 19)
                                                   : (sw << 16) / tw,
                          ($urandom_range(4) == 0) ? $urandom_range(1, 1 << 19)
                                                   : (sh << 16) / th,
                          30, 0);
         if (p == 9) begin
            hold_requests++;
            wait_drained();
            for (int i = 0; i < 30; i++) queue_sample($urandom_range(tw), $urandom_range(th));
         end
      end

      wait_drained();
      $display("covered %0d phases: %0d loads and %0d samples checked", phases_run,
               loads_seen, samples_seen);
      if (mismatches == 0 && unmatched == 0 && awaited_pixels.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d unexpected results", mismatches, unmatched);
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/brs_pkg.sv
rtl/core/brs_store.sv
rtl/core/bilinear_image_resize.sv
sim/tb_top.sv
